// ===== rtl/copy_rename_table_macros.svh =====
// assertion macros for the copy rename table
`ifndef COPY_RENAME_TABLE_MACROS_SVH
`define COPY_RENAME_TABLE_MACROS_SVH

`ifndef SYNTH
`define CRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRT_NEVER(lbl, cond, msg) \
    `CRT_ASSERT(lbl, !(cond), msg)
`else
`define CRT_ASSERT(lbl, prop, msg)
`define CRT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/crt_pkg.sv =====
// shared types and codes for the copy rename table
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    localparam int REG_W  = 8;
    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_START_BLOCK = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEF         = 3'd1;
    localparam logic [KIND_W-1:0] KIND_USE         = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COPY        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK        = 3'd4;

    // table write control
    typedef struct packed {
        logic             clear;
        logic             we_a;
        logic             we_b;
        logic [REG_W-1:0] waddr;
        logic             tv;
        logic [REG_W-1:0] tgt;
    } crt_wr_t;

    // table read control
    typedef struct packed {
        logic             ra_en;
        logic [REG_W-1:0] ra_addr;
        logic             rb_en;
        logic [REG_W-1:0] rb_addr;
    } crt_rd_t;

endpackage

`default_nettype wire

// ===== rtl/copy_rename_table.sv =====
// copy rename table top level: request decode, lookup pipeline and result register
// Usage:
//   A request is taken at a rising edge with start high and busy low. The host
//   drives kind and the operand fields with it. Every request gives exactly one
//   result, shown for one cycle with done high, once the request has passed the
//   p1, p2 and done registers; results leave in request order and the
//   receiver cannot stall them. def, copy and tick do not raise busy: a new
//   request may follow at the next edge. A use raises busy, since it reads
//   the entry ram and then the def stamp ram at the entry's target, each with
//   a registered read; busy is high in the cycle between those two reads.
//   start_block keeps the stamp and clears the table with a pass that zeroes
//   one entry per cycle: busy stays high until every table entry is zeroed,
//   and only then can the next request be taken.
//   Only use requests can report a rename; all others return zero.
//   Writes from def and copy land at the request edge, so the next request
//   already sees them.
//   Reset sets the stamp to zero and runs the same clearing pass; busy is high
//   until it ends.
`timescale 1ns / 1ps
`default_nettype none
`include "copy_rename_table_macros.svh"

module copy_rename_table #(
    parameter int NUM_VREGS  = 256,
    parameter int STAMP_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [crt_pkg::KIND_W-1:0]        kind,
    input  wire logic [crt_pkg::REG_W-1:0]         reg_req,
    input  wire logic                              reg_is_virtual,
    input  wire logic [crt_pkg::REG_W-1:0]         src_reg,
    input  wire logic                              src_is_virtual,
    input  wire logic                              skip_rename,
    input  wire logic                              dst_live_out,
    output      logic                              done,
    output      logic                              rename_found,
    output      logic [crt_pkg::REG_W-1:0]         renamed_reg
);

    logic                      accept;
    logic                      reg_in;
    logic                      src_in;
    logic                      clearing;
    crt_pkg::crt_wr_t          wr;
    crt_pkg::crt_rd_t          rd;
    logic [STAMP_BITS-1:0]     wr_rstamp;
    logic [STAMP_BITS-1:0]     wr_dstamp;
    logic                      a_tv;
    logic [crt_pkg::REG_W-1:0] a_tgt;
    logic [STAMP_BITS-1:0]     a_rstamp;
    logic [STAMP_BITS-1:0]     b_dstamp;
    logic                      found;

    logic [STAMP_BITS-1:0]     now_reg;
    logic [STAMP_BITS-1:0]     now_next;
    logic                      p1_vld_reg;
    logic                      p1_vld_next;
    logic                      p1_use_reg;
    logic                      p1_use_next;
    logic                      p1_ok_reg;
    logic                      p1_ok_next;
    logic                      p2_vld_reg;
    logic                      p2_vld_next;
    logic                      p2_ok_reg;
    logic                      p2_ok_next;
    logic [STAMP_BITS-1:0]     p2_rstamp_reg;
    logic [STAMP_BITS-1:0]     p2_rstamp_next;
    logic [crt_pkg::REG_W-1:0] p2_tgt_reg;
    logic [crt_pkg::REG_W-1:0] p2_tgt_next;
    logic                      done_reg;
    logic                      done_next;
    logic                      found_reg;
    logic                      found_next;
    logic [crt_pkg::REG_W-1:0] renamed_reg_reg;
    logic [crt_pkg::REG_W-1:0] renamed_reg_next;

    assign busy   = p1_use_reg || clearing;
    assign accept = start && !busy;
    assign reg_in = reg_is_virtual && (32'(reg_req) < NUM_VREGS);
    assign src_in = src_is_virtual && (32'(src_reg) < NUM_VREGS);

    // request decode into table writes
    always_comb
    begin
        wr        = '0;
        wr_rstamp = '0;
        wr_dstamp = '0;
        if (accept)
        begin
            unique case (kind)
                crt_pkg::KIND_START_BLOCK:
                begin
                    wr.clear = 1'b1;
                end
                crt_pkg::KIND_DEF:
                begin
                    if (reg_in)
                    begin
                        wr.we_a   = 1'b1;
                        wr.we_b   = 1'b1;
                        wr.waddr  = reg_req;
                        wr_dstamp = now_reg;
                    end
                end
                crt_pkg::KIND_COPY:
                begin
                    if (reg_in && src_in)
                    begin
                        wr.we_a   = 1'b1;
                        wr.tv     = 1'b1;
                        wr_rstamp = now_reg;
                        if (dst_live_out)
                        begin
                            // src renames to dst, src def stamp untouched
                            wr.waddr = src_reg;
                            wr.tgt   = reg_req;
                        end
                        else
                        begin
                            wr.we_b   = 1'b1;
                            wr.waddr  = reg_req;
                            wr.tgt    = src_reg;
                            wr_dstamp = now_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // first read at the operand, second at its target
    always_comb
    begin
        rd.ra_en   = accept && (kind == crt_pkg::KIND_USE);
        rd.ra_addr = reg_req;
        rd.rb_en   = p1_use_reg;
        rd.rb_addr = a_tgt;
    end

    crt_table #(
        .NUM_VREGS (NUM_VREGS),
        .STAMP_BITS(STAMP_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .wr_rstamp(wr_rstamp),
        .wr_dstamp(wr_dstamp),
        .rd       (rd),
        .clearing (clearing),
        .a_tv     (a_tv),
        .a_tgt    (a_tgt),
        .a_rstamp (a_rstamp),
        .b_dstamp (b_dstamp)
    );

    always_comb
    begin
        now_next = now_reg;
        if (accept && (kind == crt_pkg::KIND_TICK) && (now_reg != '1))
        begin
            now_next = now_reg + 1'b1;
        end
    end

    always_comb
    begin
        p1_vld_next      = accept;
        p1_use_next      = accept && (kind == crt_pkg::KIND_USE);
        p1_ok_next       = !skip_rename && reg_in;
        p2_vld_next      = p1_vld_reg;
        p2_ok_next       = p1_use_reg && p1_ok_reg && a_tv && (32'(a_tgt) < NUM_VREGS);
        p2_rstamp_next   = a_rstamp;
        p2_tgt_next      = a_tgt;
        // target must not be redefined at a later stamp than the rename
        found            = p2_ok_reg && (b_dstamp <= p2_rstamp_reg);
        done_next        = p2_vld_reg;
        found_next       = found;
        renamed_reg_next = found ? p2_tgt_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg    <= '0;
            p1_vld_reg <= 1'b0;
            p1_use_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p2_ok_reg  <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            now_reg    <= now_next;
            p1_vld_reg <= p1_vld_next;
            p1_use_reg <= p1_use_next;
            p2_vld_reg <= p2_vld_next;
            p2_ok_reg  <= p2_ok_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_ok_reg       <= p1_ok_next;
        p2_rstamp_reg   <= p2_rstamp_next;
        p2_tgt_reg      <= p2_tgt_next;
        renamed_reg_reg <= renamed_reg_next;
    end

    assign done         = done_reg;
    assign rename_found = found_reg;
    assign renamed_reg  = renamed_reg_reg;

    `CRT_ASSERT(a_result_follows, accept |-> ##3 done_reg, "request produced no result")
    `CRT_ASSERT(a_lookup_gap, p1_use_reg |=> !p1_vld_reg, "request taken during lookup")
    `CRT_NEVER(a_stamp_monotonic, now_reg < $past(now_reg), "stamp went backwards")
    `CRT_NEVER(a_found_orphan, found_reg && !done_reg, "rename reported without result")

endmodule

`default_nettype wire

// ===== rtl/crt_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/crt_table.sv =====
// rename table storage: entry ram, def stamp ram and the clearing pass
`timescale 1ns / 1ps
`default_nettype none

module crt_table #(
    parameter int NUM_VREGS  = 256,
    parameter int STAMP_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire crt_pkg::crt_wr_t              wr,
    input  wire logic [STAMP_BITS-1:0]         wr_rstamp,
    input  wire logic [STAMP_BITS-1:0]         wr_dstamp,
    input  wire crt_pkg::crt_rd_t              rd,
    output      logic                          clearing,
    output      logic                          a_tv,
    output      logic [crt_pkg::REG_W-1:0]     a_tgt,
    output      logic [STAMP_BITS-1:0]         a_rstamp,
    output      logic [STAMP_BITS-1:0]         b_dstamp
);

    // register fields cannot reach beyond the reg index range
    localparam int REG_SPAN = 1 << crt_pkg::REG_W;
    localparam int DEPTH    = (NUM_VREGS < REG_SPAN) ? NUM_VREGS : REG_SPAN;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int A_W      = 1 + crt_pkg::REG_W + STAMP_BITS;

    logic                  clr_busy_reg;
    logic                  clr_busy_next;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     clr_addr_next;
    logic                  we_a;
    logic                  we_b;
    logic [ADDR_W-1:0]     wa;
    logic [ADDR_W-1:0]     ra;
    logic [ADDR_W-1:0]     rb;
    logic [A_W-1:0]        a_wdata;
    logic [A_W-1:0]        a_rdata;
    logic [STAMP_BITS-1:0] b_wdata;
    logic [STAMP_BITS-1:0] b_rdata;

    // the clearing pass owns the write port while it runs
    assign we_a    = wr.we_a || clr_busy_reg;
    assign we_b    = wr.we_b || clr_busy_reg;
    assign wa      = clr_busy_reg ? clr_addr_reg : wr.waddr[ADDR_W-1:0];
    assign a_wdata = clr_busy_reg ? '0 : {wr.tv, wr.tgt, wr_rstamp};
    assign b_wdata = clr_busy_reg ? '0 : wr_dstamp;
    assign ra      = rd.ra_addr[ADDR_W-1:0];
    assign rb      = rd.rb_addr[ADDR_W-1:0];

    crt_ram #(
        .WIDTH(A_W),
        .DEPTH(DEPTH)
    ) u_ram_a (
        .clk  (clk),
        .we   (we_a),
        .waddr(wa),
        .wdata(a_wdata),
        .re   (rd.ra_en),
        .raddr(ra),
        .rdata(a_rdata)
    );

    crt_ram #(
        .WIDTH(STAMP_BITS),
        .DEPTH(DEPTH)
    ) u_ram_b (
        .clk  (clk),
        .we   (we_b),
        .waddr(wa),
        .wdata(b_wdata),
        .re   (rd.rb_en),
        .raddr(rb),
        .rdata(b_rdata)
    );

    // one entry zeroed per cycle after reset and after block start
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (wr.clear)
        begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign clearing = clr_busy_reg;
    assign a_tv     = a_rdata[A_W-1];
    assign a_tgt    = a_rdata[A_W-2:STAMP_BITS];
    assign a_rstamp = a_rdata[STAMP_BITS-1:0];
    assign b_dstamp = b_rdata;

endmodule

`default_nettype wire
